### rtl/interval_timer_rate_generator_defines.svh
`ifndef INTERVAL_TIMER_RATE_GENERATOR_DEFINES_SVH
`define INTERVAL_TIMER_RATE_GENERATOR_DEFINES_SVH

// invariant checked at every edge outside reset
`define ITRG_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence checked at the next edge
`define ITRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequence checked at the same edge
`define ITRG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/itrg_pkg.sv
package itrg_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_CONTROL = 2'd0;
  localparam cmd_t CMD_WRITE   = 2'd1;
  localparam cmd_t CMD_READ    = 2'd2;
  localparam cmd_t CMD_TICK    = 2'd3;

  typedef logic [1:0] access_t;

  localparam access_t ACCESS_LATCH    = 2'b00;
  localparam access_t ACCESS_LOW_HIGH = 2'b11;

  localparam logic [15:0] COUNT_ONE = 16'd1;
  localparam logic [15:0] COUNT_TWO = 16'd2;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } in_item_t;

endpackage

### rtl/itrg_if.sv
interface itrg_in_if;
  logic           valid;
  logic           ready;
  itrg_pkg::cmd_t cmd;
  logic [7:0]     data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface itrg_out_if #(
  parameter int PULSE_COUNT_BITS = 64
);
  logic                        valid;
  logic                        ready;
  logic [7:0]                  read_data;
  logic                        irq_pulse;
  logic [PULSE_COUNT_BITS-1:0] interrupts_seen;
  logic                        is_counting;

  modport source (
    output valid, output read_data, output irq_pulse,
    output interrupts_seen, output is_counting, input ready
  );
  modport sink (
    input valid, input read_data, input irq_pulse,
    input interrupts_seen, input is_counting, output ready
  );
endinterface

### rtl/itrg_in_stage.sv
module itrg_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  itrg_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output itrg_pkg::in_item_t item
);

  logic               valid_r;
  itrg_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/itrg_core.sv
`include "interval_timer_rate_generator_defines.svh"

module itrg_core #(
  parameter int PULSE_COUNT_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  itrg_pkg::in_item_t          item,
  output logic [7:0]                  read_data,
  output logic                        irq_pulse,
  output logic [PULSE_COUNT_BITS-1:0] interrupts_seen,
  output logic                        is_counting
);

  logic [15:0]                 reload_value_r, reload_value_nxt;
  logic [15:0]                 current_count_r, current_count_nxt;
  logic                        counting_on_r, counting_on_nxt;
  logic                        expect_high_write_r, expect_high_write_nxt;
  logic                        expect_high_read_r, expect_high_read_nxt;
  logic                        latch_full_r, latch_full_nxt;
  logic [15:0]                 latched_count_r, latched_count_nxt;
  logic                        load_pending_r, load_pending_nxt;
  logic [PULSE_COUNT_BITS-1:0] pulse_total_r, pulse_total_nxt;

  itrg_pkg::access_t access;
  logic              select_ok;
  logic [15:0]       full_value;
  logic [15:0]       read_src;

  assign access     = item.data_byte[5:4];
  assign select_ok  = (item.data_byte[7:6] == 2'b00);
  assign full_value = {item.data_byte, reload_value_r[7:0]};
  assign read_src   = latch_full_r ? latched_count_r : current_count_r;

  always_comb begin
    reload_value_nxt      = reload_value_r;
    current_count_nxt     = current_count_r;
    counting_on_nxt       = counting_on_r;
    expect_high_write_nxt = expect_high_write_r;
    expect_high_read_nxt  = expect_high_read_r;
    latch_full_nxt        = latch_full_r;
    latched_count_nxt     = latched_count_r;
    load_pending_nxt      = load_pending_r;
    pulse_total_nxt       = pulse_total_r;
    read_data             = 8'd0;
    irq_pulse             = 1'b0;
    case (item.cmd)
      itrg_pkg::CMD_CONTROL: begin
        if (select_ok && access == itrg_pkg::ACCESS_LATCH && !latch_full_r) begin
          latched_count_nxt    = current_count_r;
          latch_full_nxt       = 1'b1;
          expect_high_read_nxt = 1'b0;
        end else if (select_ok && access == itrg_pkg::ACCESS_LOW_HIGH) begin
          counting_on_nxt       = 1'b0;
          load_pending_nxt      = 1'b1;
          expect_high_write_nxt = 1'b0;
          expect_high_read_nxt  = 1'b0;
          latch_full_nxt        = 1'b0;
        end
      end
      itrg_pkg::CMD_WRITE: begin
        if (load_pending_r && !expect_high_write_r) begin
          reload_value_nxt      = {reload_value_r[15:8], item.data_byte};
          expect_high_write_nxt = 1'b1;
        end else if (load_pending_r) begin
          // a count of one is illegal and runs as two
          reload_value_nxt      = (full_value == itrg_pkg::COUNT_ONE) ?
                                  itrg_pkg::COUNT_TWO : full_value;
          current_count_nxt     = reload_value_nxt;
          expect_high_write_nxt = 1'b0;
          load_pending_nxt      = 1'b0;
          counting_on_nxt       = 1'b1;
          pulse_total_nxt       = '0;
        end
      end
      itrg_pkg::CMD_READ: begin
        read_data            = expect_high_read_r ? read_src[15:8] : read_src[7:0];
        expect_high_read_nxt = !expect_high_read_r;
        if (expect_high_read_r) begin
          latch_full_nxt = 1'b0;
        end
      end
      itrg_pkg::CMD_TICK: begin
        if (counting_on_r && current_count_r == itrg_pkg::COUNT_ONE) begin
          current_count_nxt = reload_value_r;
          pulse_total_nxt   = pulse_total_r + PULSE_COUNT_BITS'(1);
          irq_pulse         = 1'b1;
        end else if (counting_on_r) begin
          current_count_nxt = current_count_r - 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign interrupts_seen = pulse_total_nxt;
  assign is_counting     = counting_on_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_value_r      <= '0;
      current_count_r     <= '0;
      counting_on_r       <= 1'b0;
      expect_high_write_r <= 1'b0;
      expect_high_read_r  <= 1'b0;
      latch_full_r        <= 1'b0;
      latched_count_r     <= '0;
      load_pending_r      <= 1'b0;
      pulse_total_r       <= '0;
    end else if (fire) begin
      reload_value_r      <= reload_value_nxt;
      current_count_r     <= current_count_nxt;
      counting_on_r       <= counting_on_nxt;
      expect_high_write_r <= expect_high_write_nxt;
      expect_high_read_r  <= expect_high_read_nxt;
      latch_full_r        <= latch_full_nxt;
      latched_count_r     <= latched_count_nxt;
      load_pending_r      <= load_pending_nxt;
      pulse_total_r       <= pulse_total_nxt;
    end
  end

  `ITRG_ASSERT_ALWAYS(a_pending_not_counting, !(load_pending_r && counting_on_r),
                      "load pending while counting")
  `ITRG_ASSERT_ALWAYS(a_reload_legal, !counting_on_r || reload_value_r != itrg_pkg::COUNT_ONE,
                      "reload value of one while counting")
  `ITRG_ASSERT_SAME(a_irq_on_tick, fire && irq_pulse,
                    item.cmd == itrg_pkg::CMD_TICK && counting_on_r,
                    "interrupt without a counting tick")
  `ITRG_ASSERT_NEXT(a_load_starts, fire && item.cmd == itrg_pkg::CMD_WRITE &&
                    load_pending_r && expect_high_write_r,
                    counting_on_r && current_count_r != itrg_pkg::COUNT_ONE &&
                    pulse_total_r == '0,
                    "count load did not start counting")

endmodule

### rtl/itrg_out_stage.sv
module itrg_out_stage #(
  parameter int PULSE_COUNT_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        advance,
  input  logic [7:0]                  read_data,
  input  logic                        irq_pulse,
  input  logic [PULSE_COUNT_BITS-1:0] interrupts_seen,
  input  logic                        is_counting,
  itrg_out_if.source                  out_ch
);

  logic                        valid_r;
  logic [7:0]                  read_data_r;
  logic                        irq_pulse_r;
  logic [PULSE_COUNT_BITS-1:0] interrupts_seen_r;
  logic                        is_counting_r;

  assign advance                = !valid_r || out_ch.ready;
  assign out_ch.valid           = valid_r;
  assign out_ch.read_data       = read_data_r;
  assign out_ch.irq_pulse       = irq_pulse_r;
  assign out_ch.interrupts_seen = interrupts_seen_r;
  assign out_ch.is_counting     = is_counting_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      read_data_r       <= read_data;
      irq_pulse_r       <= irq_pulse;
      interrupts_seen_r <= interrupts_seen;
      is_counting_r     <= is_counting;
    end
  end

endmodule

### rtl/interval_timer_rate_generator.sv
// Path: accepted item -> input register -> result register.
// Throughput: 1 item per cycle unless out_ch.ready stalls; state updates
// in the single stage between the two registers, so every tick is taken.
// Reset: synchronous active-low rst_n clears all counter state, both valid
// flags and the interrupt total; the first item may be offered right after.
module interval_timer_rate_generator #(
  parameter int PULSE_COUNT_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  itrg_in_if.sink    in_ch,
  itrg_out_if.source out_ch
);

  itrg_pkg::in_item_t          in_item;
  itrg_pkg::in_item_t          item;
  logic                        item_valid;
  logic                        advance;
  logic [7:0]                  read_data;
  logic                        irq_pulse;
  logic [PULSE_COUNT_BITS-1:0] interrupts_seen;
  logic                        is_counting;

  assign in_item.cmd       = in_ch.cmd;
  assign in_item.data_byte = in_ch.data_byte;

  itrg_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  itrg_core #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (item_valid && advance),
    .item            (item),
    .read_data       (read_data),
    .irq_pulse       (irq_pulse),
    .interrupts_seen (interrupts_seen),
    .is_counting     (is_counting)
  );

  itrg_out_stage #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
  ) u_out_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .advance         (advance),
    .read_data       (read_data),
    .irq_pulse       (irq_pulse),
    .interrupts_seen (interrupts_seen),
    .is_counting     (is_counting),
    .out_ch          (out_ch)
  );

endmodule

### tb/tb_interval_timer_rate_generator.sv
`timescale 1ns / 1ps

module tb_interval_timer_rate_generator;

  localparam int PULSE_BITS = 64;
  localparam int CHUNK_ITEMS = 150;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0]            read_data;
    logic                  irq_pulse;
    logic [PULSE_BITS-1:0] interrupts_seen;
    logic                  is_counting;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itrg_in_if in_ch();
  itrg_out_if #(.PULSE_COUNT_BITS(PULSE_BITS)) out_ch();

  interval_timer_rate_generator #(
    .PULSE_COUNT_BITS(PULSE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predicted counter state
  logic [15:0]           reload_val;
  logic [15:0]           live_count;
  logic                  running;
  logic                  high_write_next;
  logic                  high_read_next;
  logic                  latch_held;
  logic [15:0]           latch_val;
  logic                  load_armed;
  logic [PULSE_BITS-1:0] irq_total;

  itrg_pkg::in_item_t pending_items[$];
  timer_result_t      counter_results_q[$];

  int send_idle_pct = 8;
  int recv_idle_pct = 79;
  int errors = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int irq_seen = 0;
  int reads_seen = 0;

  function automatic timer_result_t advance_counter(itrg_pkg::cmd_t cmd, logic [7:0] b);
    timer_result_t     r;
    logic [15:0]       src;
    itrg_pkg::access_t access;
    r = '0;
    access = b[5:4];
    case (cmd)
      itrg_pkg::CMD_CONTROL: begin
        if (b[7:6] == 2'b00) begin
          if (access == itrg_pkg::ACCESS_LATCH) begin
            if (!latch_held) begin
              latch_val = live_count;
              latch_held = 1'b1;
              high_read_next = 1'b0;
            end
          end else if (access == itrg_pkg::ACCESS_LOW_HIGH) begin
            running = 1'b0;
            load_armed = 1'b1;
            high_write_next = 1'b0;
            high_read_next = 1'b0;
            latch_held = 1'b0;
          end
        end
      end
      itrg_pkg::CMD_WRITE: begin
        if (load_armed) begin
          if (!high_write_next) begin
            reload_val[7:0] = b;
            high_write_next = 1'b1;
          end else begin
            reload_val[15:8] = b;
            if (reload_val == itrg_pkg::COUNT_ONE) reload_val = itrg_pkg::COUNT_TWO;
            high_write_next = 1'b0;
            load_armed = 1'b0;
            live_count = reload_val;
            running = 1'b1;
            irq_total = '0;
          end
        end
      end
      itrg_pkg::CMD_READ: begin
        src = latch_held ? latch_val : live_count;
        if (!high_read_next) begin
          r.read_data = src[7:0];
          high_read_next = 1'b1;
        end else begin
          r.read_data = src[15:8];
          high_read_next = 1'b0;
          latch_held = 1'b0;
        end
      end
      default: begin
        if (running) begin
          if (live_count == itrg_pkg::COUNT_ONE) begin
            live_count = reload_val;
            irq_total = irq_total + 1'b1;
            r.irq_pulse = 1'b1;
          end else begin
            live_count = live_count - 16'd1;
          end
        end
      end
    endcase
    r.interrupts_seen = irq_total;
    r.is_counting = running;
    return r;
  endfunction

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= itrg_pkg::CMD_TICK;
      in_ch.data_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        counter_results_q.push_back(advance_counter(in_ch.cmd, in_ch.data_byte));
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= pending_items[0].cmd;
          in_ch.data_byte <= pending_items[0].data_byte;
          void'(pending_items.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (out_ch.irq_pulse) irq_seen++;
        if (counter_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result read_data=%h irq=%b total=%0d counting=%b",
                   $time, out_ch.read_data, out_ch.irq_pulse, out_ch.interrupts_seen,
                   out_ch.is_counting);
        end else begin
          exp_r = counter_results_q.pop_front();
          if (out_ch.read_data !== exp_r.read_data) begin
            errors++;
            $display("%0t: read_data expected %h actual %h", $time, exp_r.read_data,
                     out_ch.read_data);
          end
          if (out_ch.irq_pulse !== exp_r.irq_pulse) begin
            errors++;
            $display("%0t: irq_pulse expected %b actual %b", $time, exp_r.irq_pulse,
                     out_ch.irq_pulse);
          end
          if (out_ch.interrupts_seen !== exp_r.interrupts_seen) begin
            errors++;
            $display("%0t: interrupts_seen expected %0d actual %0d", $time,
                     exp_r.interrupts_seen, out_ch.interrupts_seen);
          end
          if (out_ch.is_counting !== exp_r.is_counting) begin
            errors++;
            $display("%0t: is_counting expected %b actual %b", $time, exp_r.is_counting,
                     out_ch.is_counting);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_item(itrg_pkg::cmd_t cmd, logic [7:0] b);
    itrg_pkg::in_item_t it;
    it.cmd = cmd;
    it.data_byte = b;
    pending_items.push_back(it);
    if (cmd == itrg_pkg::CMD_READ) reads_seen++;
  endtask

  task automatic push_load(logic [15:0] cnt, logic [3:0] mode_bits);
    push_item(itrg_pkg::CMD_CONTROL, {2'b00, itrg_pkg::ACCESS_LOW_HIGH, mode_bits});
    push_item(itrg_pkg::CMD_WRITE, cnt[7:0]);
    push_item(itrg_pkg::CMD_WRITE, cnt[15:8]);
  endtask

  task automatic push_random_items(int n);
    int added;
    int pick;
    logic [15:0] cnt;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(4) == 0) cnt = 16'($urandom);
        else cnt = 16'($urandom_range(0, 9));
        push_load(cnt, 4'($urandom));
        added += 3;
      end else if (pick < 22) begin
        push_item(itrg_pkg::CMD_CONTROL, {2'b00, itrg_pkg::ACCESS_LATCH, 4'($urandom)});
        push_item(itrg_pkg::CMD_READ, 8'($urandom));
        added += 2;
        if ($urandom_range(1)) begin
          push_item(itrg_pkg::CMD_READ, 8'($urandom));
          added++;
        end
      end else if (pick < 32) begin
        push_item(itrg_pkg::CMD_READ, 8'($urandom));
        added++;
      end else if (pick < 88) begin
        push_item(itrg_pkg::CMD_TICK, 8'($urandom));
        added++;
      end else begin
        push_item(itrg_pkg::cmd_t'($urandom_range(3)), 8'($urandom));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || counter_results_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    reload_val = '0;
    live_count = '0;
    running = 1'b0;
    high_write_next = 1'b0;
    high_read_next = 1'b0;
    latch_held = 1'b0;
    latch_val = '0;
    load_armed = 1'b0;
    irq_total = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reads and ticks before any load, stray data write
    push_item(itrg_pkg::CMD_READ, 8'hFF);
    push_item(itrg_pkg::CMD_READ, 8'h00);
    push_item(itrg_pkg::CMD_TICK, 8'hFF);
    push_item(itrg_pkg::CMD_WRITE, 8'hFF);
    // illegal count of one runs as two
    push_load(16'h0001, 4'b0100);
    repeat (4) push_item(itrg_pkg::CMD_TICK, 8'h00);
    // latch, ignored second latch, read latched value
    push_item(itrg_pkg::CMD_CONTROL, {2'b00, itrg_pkg::ACCESS_LATCH, 4'b0000});
    push_item(itrg_pkg::CMD_TICK, 8'h00);
    push_item(itrg_pkg::CMD_CONTROL, {2'b00, itrg_pkg::ACCESS_LATCH, 4'b1111});
    push_item(itrg_pkg::CMD_READ, 8'h00);
    push_item(itrg_pkg::CMD_READ, 8'h00);
    // other counter and unsupported access modes are ignored
    push_item(itrg_pkg::CMD_CONTROL, 8'hF4);
    push_item(itrg_pkg::CMD_CONTROL, 8'h10);
    push_item(itrg_pkg::CMD_CONTROL, 8'h20);
    // zero means 65536
    push_load(16'h0000, 4'b1110);
    push_item(itrg_pkg::CMD_TICK, 8'h00);
    push_item(itrg_pkg::CMD_READ, 8'h00);
    push_item(itrg_pkg::CMD_READ, 8'h00);
    push_load(16'hFFFF, 4'b0000);
    wait_drained();

    push_random_items(CHUNK_ITEMS);
    wait_drained();
    send_idle_pct = 79;
    recv_idle_pct = 8;
    push_random_items(CHUNK_ITEMS);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_items(CHUNK_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d reads) through counter 0; %0d results checked.",
             items_accepted, reads_seen, results_checked);
    $display("Saw %0d interrupt pulses across three idle patterns.", irq_seen);
    if (errors == 0 && counter_results_q.size() == 0) begin
      $display("tb_interval_timer_rate_generator: PASS");
    end else begin
      $display("tb_interval_timer_rate_generator: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("tb_interval_timer_rate_generator: FAIL");
    $finish;
  end

endmodule
